// ===== hw/rtl/rbsi_pkg.sv =====
// Package for the ray/box slab intersection block: widths, register indexes and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
    localparam int CoordWidth = 32;
    localparam int FracBits   = 16;
    localparam int RotWidth   = 18;
    localparam int RotFrac    = 16;
    localparam int HalfWidth  = CoordWidth - 1;
    localparam int CfgWidth   = 2 * RotWidth;
    localparam int DivWidth   = 56;
    localparam int TWidth     = 56;

    localparam logic [2:0] REG_BOX_KIND = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_HALF_X   = 3'd4;
    localparam logic [2:0] REG_HALF_Y   = 3'd5;
    localparam logic [2:0] REG_HALF_Z   = 3'd6;
    localparam logic [2:0] REG_ROTATION = 3'd7;

    function automatic logic signed [CoordWidth-1:0] sat_coord(input logic signed [TWidth+8:0] v);
        logic signed [TWidth+8:0] hi;
        logic signed [TWidth+8:0] lo;
        begin
            hi = (TWidth+9)'(signed'({1'b0, {(CoordWidth-1){1'b1}}}));
            lo = -hi - 1;
            if (v > hi)
                sat_coord = hi[CoordWidth-1:0];
            else if (v < lo)
                sat_coord = lo[CoordWidth-1:0];
            else
                sat_coord = v[CoordWidth-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// Ray against one configured box by the slab method, Q16.16 fixed point.
// Depends on rbsi_pkg.
//
// One ray per cycle in while the output is not stalled, one result per ray out. The
// pipeline runs rotation, numerators, bit-serial restoring dividers (one quotient
// bit per stage), then slab merge, hit point and output; a stalled output
// holds the whole pipeline in place.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [35:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [31:0]       origin_x,
    input  wire logic signed [31:0]       origin_y,
    input  wire logic signed [31:0]       origin_z,
    input  wire logic signed [31:0]       dir_x,
    input  wire logic signed [31:0]       dir_y,
    input  wire logic signed [31:0]       dir_z,
    input  wire logic signed [31:0]       t_min,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          hit,
    output logic signed [31:0]            t_hit,
    output logic signed [31:0]            hit_x,
    output logic signed [31:0]            hit_y,
    output logic signed [31:0]            hit_z,
    output logic signed [17:0]            normal_x,
    output logic signed [17:0]            normal_y,
    output logic signed [17:0]            normal_z,
    output logic [2:0]                    face_index
);
    localparam int DW = rbsi_pkg::DivWidth;
    localparam int NS = 64;

    logic        kind_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] hx_reg, hy_reg, hz_reg;
    logic [35:0] rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            hx_reg <= '0; hy_reg <= '0; hz_reg <= '0;
            rot_reg <= 36'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbsi_pkg::REG_BOX_KIND: kind_reg <= cfg_data[0];
                rbsi_pkg::REG_CENTER_X: cx_reg <= cfg_data[31:0];
                rbsi_pkg::REG_CENTER_Y: cy_reg <= cfg_data[31:0];
                rbsi_pkg::REG_CENTER_Z: cz_reg <= cfg_data[31:0];
                rbsi_pkg::REG_HALF_X:   hx_reg <= cfg_data[30:0];
                rbsi_pkg::REG_HALF_Y:   hy_reg <= cfg_data[30:0];
                rbsi_pkg::REG_HALF_Z:   hz_reg <= cfg_data[30:0];
                rbsi_pkg::REG_ROTATION: rot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [17:0] c_w, s_w;
    assign c_w = rot_reg[17:0];
    assign s_w = rot_reg[35:18];

    logic adv;
    logic [NS-1:0] v_reg;
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], in_valid};
    end
    assign out_valid = v_reg[NS-1];

    // stage 0: relative origin; the products follow in stage 1
    logic signed [32:0] rx0_reg, ry0_reg, rz0_reg;
    logic signed [31:0] ox0_reg, oy0_reg, oz0_reg, dx0_reg, dy0_reg, dz0_reg, tm0_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx0_reg <= 33'(origin_x) - 33'(cx_reg);
            ry0_reg <= 33'(origin_y) - 33'(cy_reg);
            rz0_reg <= 33'(origin_z) - 33'(cz_reg);
            ox0_reg <= origin_x; oy0_reg <= origin_y; oz0_reg <= origin_z;
            dx0_reg <= dir_x; dy0_reg <= dir_y; dz0_reg <= dir_z; tm0_reg <= t_min;
        end
    end

    logic signed [51:0] p_rc_reg, p_rs_reg, p_yc_reg, p_xs_reg;
    logic signed [50:0] p_dxc_reg, p_dys_reg, p_dyc_reg, p_dxs_reg;
    logic signed [32:0] rz1_reg;
    logic signed [31:0] ox1_reg, oy1_reg, oz1_reg, dx1_reg, dy1_reg, dz1_reg, tm1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_rc_reg <= 52'(rx0_reg) * 52'(c_w);
            p_rs_reg <= 52'(ry0_reg) * 52'(s_w);
            p_yc_reg <= 52'(ry0_reg) * 52'(c_w);
            p_xs_reg <= 52'(rx0_reg) * 52'(s_w);
            p_dxc_reg <= 51'(dx0_reg) * 51'(c_w);
            p_dys_reg <= 51'(dy0_reg) * 51'(s_w);
            p_dyc_reg <= 51'(dy0_reg) * 51'(c_w);
            p_dxs_reg <= 51'(dx0_reg) * 51'(s_w);
            rz1_reg <= rz0_reg;
            ox1_reg <= ox0_reg; oy1_reg <= oy0_reg; oz1_reg <= oz0_reg;
            dx1_reg <= dx0_reg; dy1_reg <= dy0_reg; dz1_reg <= dz0_reg; tm1_reg <= tm0_reg;
        end
    end

    // stage 2: local frame values, slab numerators
    logic signed [53:0] sl0, sl1, sd0, sd1;
    logic signed [37:0] lo_w [3];
    logic signed [36:0] ld_w [3];
    logic [30:0] hf_w [3];
    always_comb
    begin
        sl0 = 54'(p_rc_reg) + 54'(p_rs_reg);
        sl1 = 54'(p_yc_reg) - 54'(p_xs_reg);
        sd0 = 54'(p_dxc_reg) + 54'(p_dys_reg);
        sd1 = 54'(p_dyc_reg) - 54'(p_dxs_reg);
        lo_w[0] = 38'(sl0 >>> 16);
        lo_w[1] = 38'(sl1 >>> 16);
        lo_w[2] = 38'(rz1_reg);
        ld_w[0] = 37'(sd0 >>> 16);
        ld_w[1] = 37'(sd1 >>> 16);
        ld_w[2] = 37'(dz1_reg);
        hf_w[0] = hx_reg; hf_w[1] = hy_reg; hf_w[2] = hz_reg;
    end

    // numerators (Q.32) and divisor magnitudes
    logic [DW-1:0] n1m_reg [3], n2m_reg [3];
    logic          n1n_reg [3], n2n_reg [3];
    logic [36:0]   dm_reg [3];
    logic          dn_reg [3], par_reg [3], pout_reg [3];
    logic signed [36:0] ld2_reg [3];
    logic          zk_reg;
    logic signed [31:0] ox2_reg, oy2_reg, oz2_reg, dx2_reg, dy2_reg, dz2_reg, tm2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [39:0] e1, e2;
                logic signed [37:0] hs;
                hs = 38'(signed'({1'b0, hf_w[a]}));
                e1 = -40'(hf_w[a]) - 40'(lo_w[a]);
                e2 = 40'(hf_w[a]) - 40'(lo_w[a]);
                n1n_reg[a] <= e1[39];
                n2n_reg[a] <= e2[39];
                n1m_reg[a] <= DW'(e1[39] ? -e1 : e1) << 16;
                n2m_reg[a] <= DW'(e2[39] ? -e2 : e2) << 16;
                dn_reg[a] <= ld_w[a][36];
                dm_reg[a] <= ld_w[a][36] ? 37'(-ld_w[a]) : 37'(ld_w[a]);
                par_reg[a] <= ld_w[a] == '0;
                pout_reg[a] <= (lo_w[a] < -hs) || (lo_w[a] > hs);
                ld2_reg[a] <= ld_w[a];
            end
            zk_reg <= kind_reg && (hx_reg == '0 || hy_reg == '0 || hz_reg == '0);
            ox2_reg <= ox1_reg; oy2_reg <= oy1_reg; oz2_reg <= oz1_reg;
            dx2_reg <= dx1_reg; dy2_reg <= dy1_reg; dz2_reg <= dz1_reg; tm2_reg <= tm1_reg;
        end
    end

    // divider: one quotient bit per stage, DW stages, six lanes
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] quo;
        logic [DW-1:0] num;
    } lane_t;
    typedef struct packed {
        logic [2:0]  n1n, n2n, dn, par, pout;
        logic [110:0] ld;
        logic        zk;
        logic [223:0] vec;
    } side_t;

    lane_t lane_reg [DW+1][6];
    logic [36:0] dv_reg [DW+1][3];
    side_t sd_reg [DW+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lane_reg[0][2*a].rem <= '0;
                lane_reg[0][2*a].quo <= '0;
                lane_reg[0][2*a].num <= n1m_reg[a];
                lane_reg[0][2*a+1].rem <= '0;
                lane_reg[0][2*a+1].quo <= '0;
                lane_reg[0][2*a+1].num <= n2m_reg[a];
                dv_reg[0][a] <= dm_reg[a];
                sd_reg[0].n1n[a] <= n1n_reg[a];
                sd_reg[0].n2n[a] <= n2n_reg[a];
                sd_reg[0].dn[a] <= dn_reg[a];
                sd_reg[0].par[a] <= par_reg[a];
                sd_reg[0].pout[a] <= pout_reg[a];
                sd_reg[0].ld[37*a +: 37] <= ld2_reg[a];
            end
            sd_reg[0].zk <= zk_reg;
            sd_reg[0].vec <= {ox2_reg, oy2_reg, oz2_reg, dx2_reg, dy2_reg, dz2_reg, tm2_reg};
            for (int k = 0; k < DW; k++)
            begin
                for (int l = 0; l < 6; l++)
                begin
                    logic [DW:0] r;
                    r = {lane_reg[k][l].rem, lane_reg[k][l].num[DW-1]};
                    if (r >= (DW+1)'(dv_reg[k][l/2]))
                    begin
                        lane_reg[k+1][l].rem <= DW'(r - (DW+1)'(dv_reg[k][l/2]));
                        lane_reg[k+1][l].quo <= {lane_reg[k][l].quo[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        lane_reg[k+1][l].rem <= r[DW-1:0];
                        lane_reg[k+1][l].quo <= {lane_reg[k][l].quo[DW-2:0], 1'b0};
                    end
                    lane_reg[k+1][l].num <= lane_reg[k][l].num << 1;
                end
                for (int a = 0; a < 3; a++)
                    dv_reg[k+1][a] <= dv_reg[k][a];
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    // floored signed quotients
    logic signed [DW+1:0] tq_w [6];
    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            logic neg;
            logic [DW-1:0] q;
            neg = ((l % 2 == 0) ? sd_reg[DW].n1n[l/2] : sd_reg[DW].n2n[l/2])
                  ^ sd_reg[DW].dn[l/2];
            q = lane_reg[DW][l].quo;
            if (neg)
                tq_w[l] = -(DW+2)'(q) - ((lane_reg[DW][l].rem != '0) ? (DW+2)'(1) : '0);
            else
                tq_w[l] = (DW+2)'(q);
        end
    end

    logic signed [DW+1:0] tq_reg [6];
    side_t sdm_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 6; l++)
                tq_reg[l] <= tq_w[l];
            sdm_reg <= sd_reg[DW];
        end
    end

    // merge slabs
    logic signed [DW+1:0] tn_w, tf_w, th_w;
    logic miss_w, pos_w;
    logic [1:0] ax_w;
    always_comb
    begin
        logic signed [DW+1:0] t1, t2, tm;
        logic signed [36:0] od;
        logic any, un;
        logic [1:0] na, fa;
        tn_w = '0; tf_w = '0; any = 1'b0; miss_w = sdm_reg.zk; na = '0; fa = '0;
        t1 = '0; t2 = '0;
        for (int a = 0; a < 3; a++)
        begin
            if (sdm_reg.par[a])
            begin
                if (sdm_reg.pout[a])
                    miss_w = 1'b1;
            end
            else
            begin
                t1 = tq_reg[2*a]; t2 = tq_reg[2*a+1];
                if (t1 > t2)
                begin
                    t1 = tq_reg[2*a+1]; t2 = tq_reg[2*a];
                end
                if (!any || t1 > tn_w)
                begin
                    tn_w = t1; na = 2'(a);
                end
                if (!any || t2 < tf_w)
                begin
                    tf_w = t2; fa = 2'(a);
                end
                any = 1'b1;
                if (tn_w > tf_w)
                    miss_w = 1'b1;
            end
        end
        tm = (DW+2)'(signed'(sdm_reg.vec[31:0]));
        if (!any || tf_w < tm)
            miss_w = 1'b1;
        un = tn_w >= tm;
        ax_w = un ? na : fa;
        th_w = un ? tn_w : tf_w;
        od = sdm_reg.ld[37*ax_w +: 37];
        pos_w = un ? od[36] : (od > 0);
    end

    // post stage A: register hit info; integer part of t clamped where the point saturates
    logic miss_a_reg, pos_a_reg;
    logic [1:0] ax_a_reg;
    logic signed [31:0] th_a_reg;
    logic signed [31:0] o_a_reg [3], d_a_reg [3];
    logic signed [33:0] hi_a_reg;
    logic [15:0] lo_a_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [DW+1:0] hq;
            hq = th_w >>> 16;
            miss_a_reg <= miss_w;
            pos_a_reg <= pos_w;
            ax_a_reg <= ax_w;
            th_a_reg <= rbsi_pkg::sat_coord(65'(th_w));
            if (hq[DW+1:33] == '0 || hq[DW+1:33] == '1)
                hi_a_reg <= hq[33:0];
            else
                hi_a_reg <= hq[DW+1] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
            lo_a_reg <= th_w[15:0];
            o_a_reg[0] <= sdm_reg.vec[223:192];
            o_a_reg[1] <= sdm_reg.vec[191:160];
            o_a_reg[2] <= sdm_reg.vec[159:128];
            d_a_reg[0] <= sdm_reg.vec[127:96];
            d_a_reg[1] <= sdm_reg.vec[95:64];
            d_a_reg[2] <= sdm_reg.vec[63:32];
        end
    end

    // post stage B: products of hit point
    logic signed [65:0] ph_b_reg [3];
    logic signed [48:0] pl_b_reg [3];
    logic signed [31:0] o_b_reg [3];
    logic miss_b_reg, pos_b_reg;
    logic [1:0] ax_b_reg;
    logic signed [31:0] th_b_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ph_b_reg[j] <= 66'(hi_a_reg) * 66'(d_a_reg[j]);
                pl_b_reg[j] <= 49'(signed'({1'b0, lo_a_reg})) * 49'(d_a_reg[j]);
                o_b_reg[j] <= o_a_reg[j];
            end
            miss_b_reg <= miss_a_reg; pos_b_reg <= pos_a_reg;
            ax_b_reg <= ax_a_reg; th_b_reg <= th_a_reg;
        end
    end

    // output stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [99:0] p;
            logic signed [18:0] n [3];
            if (miss_b_reg)
            begin
                hit <= 1'b0; t_hit <= '0; hit_x <= '0; hit_y <= '0; hit_z <= '0;
                normal_x <= '0; normal_y <= '0; normal_z <= '0; face_index <= '0;
            end
            else
            begin
                hit <= 1'b1;
                t_hit <= th_b_reg;
                p = 100'(ph_b_reg[0]) + 100'(pl_b_reg[0] >>> 16) + 100'(o_b_reg[0]);
                hit_x <= (p > 100'sh7fffffff) ? 32'sh7fffffff :
                         (p < -100'sh80000000) ? 32'sh80000000 : p[31:0];
                p = 100'(ph_b_reg[1]) + 100'(pl_b_reg[1] >>> 16) + 100'(o_b_reg[1]);
                hit_y <= (p > 100'sh7fffffff) ? 32'sh7fffffff :
                         (p < -100'sh80000000) ? 32'sh80000000 : p[31:0];
                p = 100'(ph_b_reg[2]) + 100'(pl_b_reg[2] >>> 16) + 100'(o_b_reg[2]);
                hit_z <= (p > 100'sh7fffffff) ? 32'sh7fffffff :
                         (p < -100'sh80000000) ? 32'sh80000000 : p[31:0];
                case (ax_b_reg)
                    2'd0:
                    begin
                        n[0] = 19'(c_w); n[1] = 19'(s_w); n[2] = '0;
                    end
                    2'd1:
                    begin
                        n[0] = -19'(s_w); n[1] = 19'(c_w); n[2] = '0;
                    end
                    default:
                    begin
                        n[0] = '0; n[1] = '0; n[2] = 19'(65536);
                    end
                endcase
                for (int j = 0; j < 3; j++)
                begin
                    if (!pos_b_reg)
                        n[j] = -n[j];
                    if (n[j] > 19'sd131071)
                        n[j] = 19'sd131071;
                    else if (n[j] < -19'sd131072)
                        n[j] = -19'sd131072;
                end
                normal_x <= n[0][17:0]; normal_y <= n[1][17:0]; normal_z <= n[2][17:0];
                face_index <= {ax_b_reg, 1'b0} + {2'b00, pos_b_reg};
            end
        end
    end
endmodule
`default_nettype wire
